@@ rtl/psqm_pkg.sv @@
// Shared types and constants for the process state queue manager.
package psqm_pkg;

	localparam int MAX_PROCESSES_DEF = 32;
	localparam int ID_W              = 16;
	localparam int PRI_W             = 2;
	localparam int DUR_W             = 16;

	typedef enum logic [2:0] {
		CMD_CREATE  = 3'd0,
		CMD_TO_CPU  = 3'd1,
		CMD_TO_BLK  = 3'd2,
		CMD_SUSPEND = 3'd3,
		CMD_RUN     = 3'd4,
		CMD_RESUME  = 3'd5,
		CMD_UNBLOCK = 3'd6,
		CMD_DELETE  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_BAD_PRI  = 3'd2,
		ST_BAD_DUR  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		LST_READY = 2'd0,
		LST_CPU   = 2'd1,
		LST_SUSP  = 2'd2,
		LST_BLK   = 2'd3
	} list_t;

	localparam logic [PRI_W-1:0] PRI_REJECT  = 2'd3;
	localparam logic [PRI_W-1:0] PRI_UNBLOCK = 2'd1;
	localparam logic [DUR_W-1:0] DUR_UNBLOCK = 16'd2;

	typedef struct packed {
		cmd_t              command;
		logic [ID_W-1:0]   proc_id;
		logic [PRI_W-1:0]  priority_req;
		logic [DUR_W-1:0]  duration;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   out_id;
		logic [PRI_W-1:0]  out_priority;
		logic [DUR_W-1:0]  remaining;
		logic              finished;
		logic [1:0]        found_in;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRI_W-1:0]  pri;
		logic [DUR_W-1:0]  dur;
	} ent_t;

endpackage

@@ rtl/psqm_stream_if.sv @@
// Valid/ready stream interface carrying one request or response payload.
interface psqm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/psqm_store.sv @@
// Entry store: field memory and link memory, one write each, registered read.
module psqm_store
	import psqm_pkg::*;
#(
	parameter int DEPTH = MAX_PROCESSES_DEF,
	parameter int IW    = $clog2(MAX_PROCESSES_DEF + 1)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic          wd_en,
	input  logic [IW-1:0] wd_addr,
	input  ent_t          wd_data,
	input  logic          wl_en,
	input  logic [IW-1:0] wl_addr,
	input  logic [IW-1:0] wl_data,
	output ent_t          rd_dat,
	output logic [IW-1:0] rd_lnk
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ent_t          dat_mem [DEPTH];
	logic [IW-1:0] lnk_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wd_en) begin
			dat_mem[wd_addr[AW-1:0]] <= wd_data;
		end
		if (rd_en) begin
			rd_dat <= dat_mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wl_en) begin
			lnk_mem[wl_addr[AW-1:0]] <= wl_data;
		end
		if (rd_en) begin
			rd_lnk <= lnk_mem[rd_addr[AW-1:0]];
		end
	end
endmodule

@@ rtl/process_state_queue_manager.sv @@
// Process state queue manager: one command request in, one result out. Entries
// live in a field memory and a link memory; a sequencer walks the ready list,
// the priority-ordered CPU queue, the suspended stack and the blocked queue,
// reading each entry in an address step, then comparing on the registered
// data. A move or delete walks its lists entry by entry up to the match, and
// a move to the CPU queue also walks that queue for priority insertion. Create
// searches all four lists. One request is worked at a time; a new one is taken
// while the previous result still waits in the output register, and the result
// stalls only in the final step. No clearing pass after reset: the free list is
// implicit above a fill mark, so the block accepts requests straight out of
// reset.
module process_state_queue_manager
	import psqm_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	psqm_stream_if.sink    req,
	psqm_stream_if.source  rsp
);
	localparam int IW = $clog2(MAX_PROCESSES + 1);
	localparam logic [IW-1:0] NIL = IW'(MAX_PROCESSES);

	typedef enum logic [4:0] {
		S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_UNLINK, S_INS_RD0, S_INS_CHK0,
		S_INS_LOOP, S_INS_CHK, S_INS_HEAD, S_INS_W1, S_INS_W2, S_SUSP_PUSH,
		S_FREE, S_ALLOC, S_ALLOC_RD, S_POP_CHK, S_APP1, S_APP2, S_FIN
	} state_t;

	state_t        state_q;

	// list anchors and the free stack, with the fill mark for never-used entries
	logic [IW-1:0] ready_head_q, ready_tail_q, cpu_head_q, susp_top_q;
	logic [IW-1:0] blk_head_q, blk_tail_q, free_head_q, fill_q;

	// working registers of the current request
	cmd_t             cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [PRI_W-1:0] pr_q;
	logic [DUR_W-1:0] dur_q;
	list_t            lst_q;
	logic [IW-1:0]    cur_q, prev_q, e_q, nx_q, t_q, tl_q;
	logic [PRI_W-1:0] epr_q;
	logic             app_blk_q;
	rsp_t             res_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// store ports
	logic          rd_en, wd_en, wl_en;
	logic [IW-1:0] rd_addr, wd_addr, wl_addr, wl_data;
	ent_t          wd_data, rd_dat;
	logic [IW-1:0] rd_lnk;

	logic             req_acc;
	logic [DUR_W-1:0] dur_dec;
	logic [IW-1:0]    next_head;
	logic [IW-1:0]    app_tail;

	psqm_store #(.DEPTH(MAX_PROCESSES), .IW(IW)) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wd_en   (wd_en),
		.wd_addr (wd_addr),
		.wd_data (wd_data),
		.wl_en   (wl_en),
		.wl_addr (wl_addr),
		.wl_data (wl_data),
		.rd_dat  (rd_dat),
		.rd_lnk  (rd_lnk)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign dur_dec   = rd_dat.dur - DUR_W'(1);
	assign app_tail  = app_blk_q ? blk_tail_q : ready_tail_q;

	// head of the list searched after the current one
	always_comb begin
		case (lst_q)
			LST_READY: next_head = cpu_head_q;
			LST_CPU:   next_head = susp_top_q;
			LST_SUSP:  next_head = blk_head_q;
			default:   next_head = ready_head_q;
		endcase
	end

	// memory accesses of each step; only the allocation step both reads and writes, at the same entry
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wd_en   = 1'b0;
		wd_addr = e_q;
		wd_data = '{id: rd_dat.id, pri: rd_dat.pri, dur: dur_dec};
		wl_en   = 1'b0;
		wl_addr = e_q;
		wl_data = NIL;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					case (req.data.command)
						CMD_RUN:     rd_addr = cpu_head_q;
						CMD_RESUME:  rd_addr = susp_top_q;
						default:     rd_addr = blk_head_q;
					endcase
					rd_en = (req.data.command == CMD_RUN || req.data.command == CMD_RESUME ||
						req.data.command == CMD_UNBLOCK) && (rd_addr != NIL);
				end
			end
			S_SRCH_RD: begin
				rd_en = (cur_q != NIL);
			end
			S_UNLINK: begin
				wl_en   = (prev_q != NIL);
				wl_addr = prev_q;
				wl_data = nx_q;
			end
			S_INS_RD0: begin
				rd_en   = 1'b1;
				rd_addr = t_q;
			end
			S_INS_LOOP: begin
				rd_en   = (tl_q != NIL);
				rd_addr = tl_q;
			end
			S_INS_HEAD: begin
				wl_en   = 1'b1;
				wl_data = cpu_head_q;
			end
			S_INS_W1: begin
				wl_en   = 1'b1;
				wl_data = tl_q;
			end
			S_INS_W2: begin
				wl_en   = 1'b1;
				wl_addr = t_q;
				wl_data = e_q;
			end
			S_SUSP_PUSH: begin
				wl_en   = 1'b1;
				wl_data = susp_top_q;
			end
			S_FREE: begin
				wl_en   = 1'b1;
				wl_data = free_head_q;
			end
			S_ALLOC: begin
				wd_en   = 1'b1;
				wd_addr = free_head_q;
				wd_data = '{id: id_q, pri: pr_q, dur: dur_q};
				rd_en   = (free_head_q != fill_q);
				rd_addr = free_head_q;
			end
			S_POP_CHK: begin
				if (cmd_q == CMD_RUN) begin
					wd_en = 1'b1;
				end else if (cmd_q == CMD_UNBLOCK) begin
					wd_en   = 1'b1;
					wd_data = '{id: rd_dat.id, pri: PRI_UNBLOCK, dur: DUR_UNBLOCK};
				end
			end
			S_APP1: begin
				wl_en = 1'b1;
			end
			S_APP2: begin
				wl_en   = (app_tail != NIL);
				wl_addr = app_tail;
				wl_data = e_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ready_head_q <= NIL;
			ready_tail_q <= NIL;
			cpu_head_q   <= NIL;
			susp_top_q   <= NIL;
			blk_head_q   <= NIL;
			blk_tail_q   <= NIL;
			free_head_q  <= '0;
			fill_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						cmd_q     <= req.data.command;
						id_q      <= req.data.proc_id;
						pr_q      <= req.data.priority_req;
						dur_q     <= req.data.duration;
						res_q     <= '0;
						app_blk_q <= 1'b0;
						lst_q     <= LST_READY;
						cur_q     <= ready_head_q;
						prev_q    <= NIL;
						case (req.data.command)
							CMD_RUN: begin
								e_q     <= cpu_head_q;
								state_q <= (cpu_head_q == NIL) ? S_FIN : S_POP_CHK;
								if (cpu_head_q == NIL) res_q.status <= ST_NOTFOUND;
							end
							CMD_RESUME: begin
								e_q     <= susp_top_q;
								state_q <= (susp_top_q == NIL) ? S_FIN : S_POP_CHK;
								if (susp_top_q == NIL) res_q.status <= ST_NOTFOUND;
							end
							CMD_UNBLOCK: begin
								e_q     <= blk_head_q;
								state_q <= (blk_head_q == NIL) ? S_FIN : S_POP_CHK;
								if (blk_head_q == NIL) res_q.status <= ST_NOTFOUND;
							end
							default: state_q <= S_SRCH_RD;
						endcase
					end
				end
				S_SRCH_RD: begin
					if (cur_q != NIL) begin
						state_q <= S_SRCH_CHK;
					end else begin
						case (cmd_q)
							CMD_CREATE: begin
								if (lst_q != LST_BLK) begin
									lst_q  <= list_t'(lst_q + 2'd1);
									cur_q  <= next_head;
									prev_q <= NIL;
								end else if (pr_q == PRI_REJECT) begin
									res_q.status <= ST_BAD_PRI;
									state_q      <= S_FIN;
								end else if (dur_q == '0) begin
									res_q.status <= ST_BAD_DUR;
									state_q      <= S_FIN;
								end else if (free_head_q == NIL) begin
									res_q.status <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									state_q <= S_ALLOC;
								end
							end
							CMD_DELETE: begin
								// search ready, then CPU queue, then suspended stack
								if (lst_q == LST_READY || lst_q == LST_CPU) begin
									lst_q  <= list_t'(lst_q + 2'd1);
									cur_q  <= next_head;
									prev_q <= NIL;
								end else begin
									res_q.status <= ST_NOTFOUND;
									state_q      <= S_FIN;
								end
							end
							default: begin
								res_q.status <= ST_NOTFOUND;
								state_q      <= S_FIN;
							end
						endcase
					end
				end
				S_SRCH_CHK: begin
					if (rd_dat.id == id_q) begin
						e_q   <= cur_q;
						nx_q  <= rd_lnk;
						epr_q <= rd_dat.pri;
						if (cmd_q == CMD_CREATE) begin
							res_q.status <= ST_DUP;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_UNLINK;
						end
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rd_lnk;
						state_q <= S_SRCH_RD;
					end
				end
				S_UNLINK: begin
					if (prev_q == NIL) begin
						case (lst_q)
							LST_READY: ready_head_q <= nx_q;
							LST_CPU:   cpu_head_q   <= nx_q;
							default:   susp_top_q   <= nx_q;
						endcase
					end
					if (lst_q == LST_READY && ready_tail_q == e_q) begin
						ready_tail_q <= prev_q;
					end
					case (cmd_q)
						CMD_DELETE: begin
							res_q.found_in <= lst_q;
							state_q        <= S_FREE;
						end
						CMD_TO_CPU: begin
							t_q     <= cpu_head_q;
							state_q <= (cpu_head_q == NIL) ? S_INS_HEAD : S_INS_RD0;
						end
						CMD_TO_BLK: begin
							app_blk_q <= 1'b1;
							state_q   <= S_APP1;
						end
						default: state_q <= S_SUSP_PUSH;
					endcase
				end
				S_INS_RD0: state_q <= S_INS_CHK0;
				S_INS_CHK0: begin
					if (epr_q > rd_dat.pri) begin
						state_q <= S_INS_HEAD;
					end else begin
						tl_q    <= rd_lnk;
						state_q <= S_INS_LOOP;
					end
				end
				S_INS_LOOP: begin
					state_q <= (tl_q == NIL) ? S_INS_W1 : S_INS_CHK;
				end
				S_INS_CHK: begin
					// stop before the first lower priority, stable among equals
					if (rd_dat.pri < epr_q) begin
						state_q <= S_INS_W1;
					end else begin
						t_q     <= tl_q;
						tl_q    <= rd_lnk;
						state_q <= S_INS_LOOP;
					end
				end
				S_INS_HEAD: begin
					cpu_head_q <= e_q;
					state_q    <= S_FIN;
				end
				S_INS_W1: state_q <= S_INS_W2;
				S_INS_W2: state_q <= S_FIN;
				S_SUSP_PUSH: begin
					susp_top_q <= e_q;
					state_q    <= S_FIN;
				end
				S_FREE: begin
					free_head_q <= e_q;
					state_q     <= S_FIN;
				end
				S_ALLOC: begin
					e_q <= free_head_q;
					if (free_head_q == fill_q) begin
						// first use of this entry: its free link is the next one up
						free_head_q <= fill_q + IW'(1);
						fill_q      <= fill_q + IW'(1);
						state_q     <= S_APP1;
					end else begin
						state_q <= S_ALLOC_RD;
					end
				end
				S_ALLOC_RD: begin
					free_head_q <= rd_lnk;
					state_q     <= S_APP1;
				end
				S_POP_CHK: begin
					res_q.out_id <= rd_dat.id;
					state_q      <= S_APP1;
					case (cmd_q)
						CMD_RUN: begin
							cpu_head_q         <= rd_lnk;
							res_q.out_priority <= rd_dat.pri;
							res_q.remaining    <= dur_dec;
							if (dur_dec == '0) begin
								res_q.finished <= 1'b1;
								state_q        <= S_FREE;
							end
						end
						CMD_RESUME: susp_top_q <= rd_lnk;
						default: begin
							blk_head_q <= rd_lnk;
							if (blk_tail_q == e_q) blk_tail_q <= NIL;
						end
					endcase
				end
				S_APP1: state_q <= S_APP2;
				S_APP2: begin
					if (app_blk_q) begin
						if (blk_tail_q == NIL) blk_head_q <= e_q;
						blk_tail_q <= e_q;
					end else begin
						if (ready_tail_q == NIL) ready_head_q <= e_q;
						ready_tail_q <= e_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold the result until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/psqm_checker.sv @@
// Port-level checks for the process state queue manager, bound to the top level.
module psqm_checker
	import psqm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
		rsp_data.out_id == '0 && rsp_data.out_priority == '0 &&
		rsp_data.remaining == '0 && !rsp_data.finished && rsp_data.found_in == '0)
		else $error("failed command with nonzero fields");

	a_finished: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.finished |->
		rsp_data.status == ST_OK && rsp_data.remaining == '0)
		else $error("finished without zero remaining");
endmodule

bind process_state_queue_manager psqm_checker u_psqm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
